// ----- rtl/terminal_line_editor_macros.svh -----
// Assertion macros shared by the terminal line editor RTL.
`ifndef TERMINAL_LINE_EDITOR_MACROS_SVH
`define TERMINAL_LINE_EDITOR_MACROS_SVH

// Check a condition at every rising edge outside reset.
`define TLE_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TLE_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tle_pkg.sv -----
// Types and constants of the terminal line editor.
package tle_pkg;

   // Character codes
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_SPACE = 8'd32;

   // Result event codes
   localparam logic [2:0] EV_ECHO   = 3'd0;
   localparam logic [2:0] EV_DONE   = 3'd1;
   localparam logic [2:0] EV_PROMPT = 3'd2;
   localparam logic [2:0] EV_EXIT   = 3'd3;
   localparam logic [2:0] EV_READ   = 3'd4;

   // Request kinds
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_ABORT     = 2'd0;
   localparam logic [1:0] CSR_BACKSPACE = 2'd1;
   localparam logic [1:0] CSR_INTRO     = 2'd2;

   // Escape sequence phases
   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_OPEN  = 2'd1;
   localparam logic [1:0] ESC_INTRO = 2'd2;

   // Result sequence that one accepted item produces
   typedef enum logic [2:0] {
      KIND_ECHO   = 3'd0,
      KIND_DONE   = 3'd1,
      KIND_PROMPT = 3'd2,
      KIND_ERASE  = 3'd3,
      KIND_EXIT   = 3'd4,
      KIND_READ   = 3'd5
   } kind_type;

endpackage

// ----- rtl/tle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/terminal_line_editor.sv -----
// Terminal line editor: line assembly, echo generation and line store readout.
// An accepted item goes into the job register, then its results into the output register.
// Results leave a single output register at one result per cycle while rsp_stall is low;
// a new item is taken as the last result of the current one moves into the output register.
// Reset (synchronous): counts and escape state cleared, registers to 3, 8 and 91;
// the line store is not cleared and needs no clearing pass.
`include "terminal_line_editor_macros.svh"

module terminal_line_editor #(
   parameter int LINE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   input  logic [6:0]  req_read_index,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_out_byte,
   output logic [6:0]  rsp_line_len,
   output logic        rsp_last,
   // Configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import tle_pkg::*;

   localparam int ADDR_W = $clog2(LINE_DEPTH);
   // Usable line length: one entry short of the store, and never above 127
   localparam int CAP_INT = (LINE_DEPTH - 1 > 127) ? 127 : LINE_DEPTH - 1;
   localparam logic [6:0] CAPACITY = 7'(CAP_INT);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [7:0] abort_char_ff, abort_char_in;
   logic [7:0] backspace_char_ff, backspace_char_in;
   logic [7:0] escape_intro_ff, escape_intro_in;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      abort_char_in     = abort_char_ff;
      backspace_char_in = backspace_char_ff;
      escape_intro_in   = escape_intro_ff;
      prdata            = 32'd0;
      unique case (paddr[3:2])
         CSR_ABORT: begin
            prdata = {24'd0, abort_char_ff};
            if (csr_write) begin
               abort_char_in = pwdata[7:0];
            end
         end
         CSR_BACKSPACE: begin
            prdata = {24'd0, backspace_char_ff};
            if (csr_write) begin
               backspace_char_in = pwdata[7:0];
            end
         end
         CSR_INTRO: begin
            prdata = {24'd0, escape_intro_ff};
            if (csr_write) begin
               escape_intro_in = pwdata[7:0];
            end
         end
         default: begin
            // Unmapped slot: reads zero, drop writes
            prdata = 32'd0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake control
   // ------------------------------------------------------------------
   // The job register holds the result sequence of the item in flight;
   // it drains one result per cycle into the output register while that register can load. A new item
   // is taken when no job is pending or the last result of the current
   // job moves into the output register in this cycle.
   logic       job_valid_ff, job_valid_in;
   kind_type   job_kind_ff, job_kind_in;
   logic [7:0] job_byte_ff, job_byte_in;
   logic [6:0] job_len_ff, job_len_in;
   logic       job_read_ok_ff, job_read_ok_in;
   logic [1:0] job_step_ff, job_step_in;
   logic [1:0] job_num;
   logic       job_last;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_event_ff, rsp_event_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [6:0] rsp_len_ff, rsp_len_in;
   logic       rsp_last_ff, rsp_last_in;

   logic out_load;
   logic emit;
   logic accept;

   always_comb begin
      case (job_kind_ff) inside
         KIND_DONE, KIND_PROMPT, KIND_ERASE: job_num = 2'd3;
         default:                            job_num = 2'd1;
      endcase
   end

   assign job_last  = (job_step_ff == job_num - 2'd1);
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = job_valid_ff && out_load;
   assign req_stall = job_valid_ff && !(emit && job_last);
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Line state and byte decoding
   // ------------------------------------------------------------------
   logic [6:0] stored_count_ff, stored_count_in;
   logic [1:0] plus_run_ff, plus_run_in;
   logic [1:0] escape_phase_ff, escape_phase_in;
   logic       line_closed_ff, line_closed_in;

   logic       has_result;
   logic       store_byte;
   logic       session_exit;
   logic       read_ok;

   assign read_ok = (req_read_index < stored_count_ff);

   always_comb begin
      stored_count_in = stored_count_ff;
      plus_run_in     = plus_run_ff;
      escape_phase_in = escape_phase_ff;
      line_closed_in  = line_closed_ff;
      has_result      = 1'b0;
      store_byte      = 1'b0;
      session_exit    = 1'b0;
      job_kind_in     = KIND_ECHO;
      job_len_in      = stored_count_ff;

      if (accept && req_type == REQ_READ) begin
         // Reads leave the line untouched and always answer once
         has_result  = 1'b1;
         job_kind_in = KIND_READ;
      end else if (accept) begin
         // A byte after a closed line starts a fresh one
         if (line_closed_ff) begin
            stored_count_in = 7'd0;
            plus_run_in     = 2'd0;
            escape_phase_in = ESC_NONE;
            line_closed_in  = 1'b0;
         end

         if (req_rx_byte == CH_PLUS) begin
            if (plus_run_in == 2'd2) begin
               // Third plus in a row ends the session
               plus_run_in    = 2'd0;
               line_closed_in = 1'b1;
               session_exit   = 1'b1;
               has_result     = 1'b1;
               job_kind_in    = KIND_EXIT;
            end else begin
               plus_run_in = plus_run_in + 2'd1;
            end
         end else begin
            plus_run_in = 2'd0;
         end

         if (!session_exit) begin
            if (req_rx_byte == CH_LF || req_rx_byte == CH_CR) begin
               escape_phase_in = ESC_NONE;
               line_closed_in  = 1'b1;
               has_result      = 1'b1;
               job_kind_in     = KIND_DONE;
            end else if (req_rx_byte == abort_char_ff) begin
               escape_phase_in = ESC_NONE;
               stored_count_in = 7'd0;
               has_result      = 1'b1;
               job_kind_in     = KIND_PROMPT;
            end else if (req_rx_byte == backspace_char_ff) begin
               escape_phase_in = ESC_NONE;
               // Erase only when something is stored; otherwise stay silent
               if (stored_count_in != 7'd0) begin
                  stored_count_in = stored_count_in - 7'd1;
                  has_result      = 1'b1;
                  job_kind_in     = KIND_ERASE;
               end
            end else if (req_rx_byte == CH_ESC) begin
               escape_phase_in = ESC_OPEN;
            end else if (escape_phase_in == ESC_OPEN && req_rx_byte == escape_intro_ff) begin
               escape_phase_in = ESC_INTRO;
            end else if (escape_phase_in == ESC_INTRO) begin
               // Final byte of the sequence: swallow it
               escape_phase_in = ESC_NONE;
            end else begin
               // Ordinary byte: echo always, store while room is left
               escape_phase_in = ESC_NONE;
               has_result      = 1'b1;
               job_kind_in     = KIND_ECHO;
               if (stored_count_in < CAPACITY) begin
                  store_byte      = 1'b1;
                  stored_count_in = stored_count_in + 7'd1;
               end
            end
         end
         job_len_in = stored_count_in;
      end
   end

   // ------------------------------------------------------------------
   // Line store
   // ------------------------------------------------------------------
   // Write at the transfer of an ordinary byte, read at the transfer of a
   // read request. Only one item transfers per cycle, so a read never meets
   // a write of the same cycle; a write is in the array before any later
   // read is issued, so no forwarding is needed. Read data stays put until
   // the next read transfer, which waits for the current job to drain.
   logic [15:0]       wr_wide;
   logic [15:0]       rd_wide;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic [6:0]        write_pos;

   // Store position is the count after a possible line restart
   assign write_pos   = line_closed_ff ? 7'd0 : stored_count_ff;
   assign wr_wide     = {9'd0, write_pos};
   assign rd_wide     = {9'd0, req_read_index};
   assign ram_wr_addr = wr_wide[ADDR_W-1:0];
   assign ram_rd_addr = rd_wide[ADDR_W-1:0];

   tle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (store_byte),
      .wr_addr (ram_wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (accept && req_type == REQ_READ),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Job register and result sequencing
   // ------------------------------------------------------------------
   assign job_byte_in    = req_rx_byte;
   assign job_read_ok_in = read_ok;

   always_comb begin
      job_valid_in = job_valid_ff;
      job_step_in  = job_step_ff;
      if (accept) begin
         job_valid_in = has_result;
         job_step_in  = 2'd0;
      end else if (emit) begin
         if (job_last) begin
            job_valid_in = 1'b0;
         end else begin
            job_step_in = job_step_ff + 2'd1;
         end
      end
   end

   // Pick the result of the current step
   always_comb begin
      rsp_event_in = EV_ECHO;
      rsp_byte_in  = 8'd0;
      case (job_kind_ff) inside
         KIND_DONE, KIND_PROMPT: begin
            // CR, LF, then the closing event
            if (job_step_ff == 2'd0) begin
               rsp_byte_in = CH_CR;
            end else if (job_step_ff == 2'd1) begin
               rsp_byte_in = CH_LF;
            end else begin
               rsp_event_in = (job_kind_ff == KIND_DONE) ? EV_DONE : EV_PROMPT;
            end
         end
         KIND_ERASE: begin
            // BS, space, BS
            rsp_byte_in = (job_step_ff == 2'd1) ? CH_SPACE : CH_BS;
         end
         KIND_EXIT: begin
            rsp_event_in = EV_EXIT;
         end
         KIND_READ: begin
            rsp_event_in = EV_READ;
            rsp_byte_in  = job_read_ok_ff ? ram_rd_data : 8'd0;
         end
         default: begin
            rsp_byte_in = job_byte_ff;
         end
      endcase
   end

   assign rsp_len_in  = job_len_ff;
   assign rsp_last_in = job_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = emit;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         abort_char_ff     <= 8'd3;
         backspace_char_ff <= 8'd8;
         escape_intro_ff   <= 8'd91;
         stored_count_ff   <= 7'd0;
         plus_run_ff       <= 2'd0;
         escape_phase_ff   <= ESC_NONE;
         line_closed_ff    <= 1'b0;
         job_valid_ff      <= 1'b0;
         job_step_ff       <= 2'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         abort_char_ff     <= abort_char_in;
         backspace_char_ff <= backspace_char_in;
         escape_intro_ff   <= escape_intro_in;
         stored_count_ff   <= stored_count_in;
         plus_run_ff       <= plus_run_in;
         escape_phase_ff   <= escape_phase_in;
         line_closed_ff    <= line_closed_in;
         job_valid_ff      <= job_valid_in;
         job_step_ff       <= job_step_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         job_kind_ff    <= job_kind_in;
         job_byte_ff    <= job_byte_in;
         job_len_ff     <= job_len_in;
         job_read_ok_ff <= job_read_ok_in;
      end
      if (emit) begin
         rsp_event_ff <= rsp_event_in;
         rsp_byte_ff  <= rsp_byte_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_line_len  = rsp_len_ff;
   assign rsp_last      = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   logic third_plus;
   logic exit_loaded;

   assign third_plus  = accept && req_type == REQ_BYTE && req_rx_byte == CH_PLUS &&
                        plus_run_ff == 2'd2 && !line_closed_ff;
   assign exit_loaded = line_closed_ff && plus_run_ff == 2'd0 && job_valid_ff &&
                        job_kind_ff == KIND_EXIT;

   `TLE_ASSERT(a_count_cap, stored_count_ff <= CAPACITY, "line count beyond capacity")
   `TLE_ASSERT(a_plus_run, plus_run_ff != 2'd3, "plus run reached three without exit")
   `TLE_ASSERT(a_job_step, !job_valid_ff || job_step_ff < job_num, "job step past its sequence")
   `TLE_ASSERT_NEXT(a_exit_close, third_plus, exit_loaded, "third plus did not close the session")

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the terminal line editor: directed table, then random lines.
`timescale 1ns / 100ps

module testbench;
   import tle_pkg::*;

   // Run limits and timing
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;    // margin after the last result transfer
   localparam int LINE_CAP      = 127;  // smaller of LINE_DEPTH - 1 and 127
   localparam int BATCH_ITEMS   = 35;

   // Register values after reset
   localparam logic [7:0] ABORT_RESET = 8'h03;
   localparam logic [7:0] ERASE_RESET = 8'h08;
   localparam logic [7:0] INTRO_RESET = 8'h5B;

   // One result of the block, field by field
   typedef struct packed {
      logic [2:0] ev;
      logic [7:0] data;
      logic [6:0] len;
      logic       last;
   } line_result_type;

   // One row of the directed table; fixed rows carry the first result typed in
   typedef struct {
      logic       typ;
      logic [7:0] ch;
      logic [6:0] idx;
      bit         fixed;
      logic [2:0] ev;
      logic [7:0] data;
      logic [6:0] len;
   } drill_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [7:0]  req_rx_byte;
   logic [6:0]  req_read_index;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_out_byte;
   logic [6:0]  rsp_line_len;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   terminal_line_editor u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_rx_byte    (req_rx_byte),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_res  (rsp_event_res),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_line_len   (rsp_line_len),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // Shadow of the editor: line store, counters, escape phase and registers
   logic [7:0]   line_mem [LINE_CAP + 1];
   logic [6:0]   line_count  = '0;
   logic [1:0]   plus_count  = '0;
   logic [1:0]   esc_state   = ESC_NONE;
   logic         line_ended  = 1'b0;
   logic [7:0]   abort_code  = ABORT_RESET;
   logic [7:0]   erase_code  = ERASE_RESET;
   logic [7:0]   intro_code  = INTRO_RESET;

   line_result_type due_results [$];   // echoes and events still owed by the block
   int           mismatches  = 0;
   int           items_sent  = 0;
   int           cycle_count = 0;
   int           send_gap_pct = 12;
   int           recv_stall_pct = 52;

   // Directed table: extremes, every request kind and the corner cases of the editor
   drill_row_type drill [26] = '{
      '{REQ_READ, 8'h00,   7'd0,   1, EV_READ, 8'h00,    7'd0},  // read of an empty line
      '{REQ_BYTE, CH_BS,   7'd0,   0, EV_ECHO, 8'h00,    7'd0},  // erase on empty line: silent
      '{REQ_BYTE, 8'h00,   7'd127, 1, EV_ECHO, 8'h00,    7'd1},
      '{REQ_BYTE, 8'hFF,   7'd0,   1, EV_ECHO, 8'hFF,    7'd2},
      '{REQ_READ, 8'hFF,   7'd1,   1, EV_READ, 8'hFF,    7'd2},
      '{REQ_READ, 8'h00,   7'd127, 1, EV_READ, 8'h00,    7'd2},  // index beyond the line
      '{REQ_BYTE, CH_BS,   7'd0,   1, EV_ECHO, CH_BS,    7'd1},
      '{REQ_BYTE, CH_ESC,  7'd0,   0, EV_ECHO, 8'h00,    7'd0},
      '{REQ_BYTE, INTRO_RESET, 7'd0, 0, EV_ECHO, 8'h00,  7'd0},
      '{REQ_BYTE, 8'h41,   7'd0,   0, EV_ECHO, 8'h00,    7'd0},  // swallowed final byte
      '{REQ_BYTE, CH_ESC,  7'd0,   0, EV_ECHO, 8'h00,    7'd0},
      '{REQ_BYTE, 8'h78,   7'd0,   1, EV_ECHO, 8'h78,    7'd2},  // escape without introducer
      '{REQ_BYTE, CH_ESC,  7'd0,   0, EV_ECHO, 8'h00,    7'd0},
      '{REQ_BYTE, CH_CR,   7'd0,   1, EV_ECHO, CH_CR,    7'd2},  // CR cancels the escape
      '{REQ_BYTE, 8'h61,   7'd0,   1, EV_ECHO, 8'h61,    7'd1},  // line restarts after close
      '{REQ_BYTE, CH_PLUS, 7'd0,   0, EV_ECHO, 8'h00,    7'd0},
      '{REQ_BYTE, CH_PLUS, 7'd0,   0, EV_ECHO, 8'h00,    7'd0},
      '{REQ_BYTE, CH_PLUS, 7'd0,   1, EV_EXIT, 8'h00,    7'd3},  // third plus in a row
      '{REQ_BYTE, CH_PLUS, 7'd0,   1, EV_ECHO, CH_PLUS,  7'd1},
      '{REQ_BYTE, CH_ESC,  7'd0,   0, EV_ECHO, 8'h00,    7'd0},
      '{REQ_BYTE, ABORT_RESET, 7'd0, 1, EV_ECHO, CH_CR,  7'd0},  // abort inside an escape
      '{REQ_BYTE, CH_ESC,  7'd0,   0, EV_ECHO, 8'h00,    7'd0},
      '{REQ_BYTE, CH_ESC,  7'd0,   0, EV_ECHO, 8'h00,    7'd0},  // second ESC restarts it
      '{REQ_BYTE, INTRO_RESET, 7'd0, 0, EV_ECHO, 8'h00,  7'd0},
      '{REQ_BYTE, 8'h2A,   7'd0,   0, EV_ECHO, 8'h00,    7'd0},
      '{REQ_BYTE, CH_LF,   7'd0,   1, EV_ECHO, CH_CR,    7'd0}   // empty line ends
   };

   // Register settings per batch: defaults, both extremes, overlapping codes, random
   logic [7:0] batch_regs [5][3] = '{
      '{ABORT_RESET, ERASE_RESET, INTRO_RESET},
      '{8'h00, 8'hFF, 8'h00},
      '{8'hFF, 8'h00, 8'hFF},
      '{CH_LF, CH_PLUS, CH_ESC},   // LF beats abort, ESC beats introducer
      '{CH_ESC, CH_CR, CH_PLUS}    // abort beats ESC, CR beats erase
   };

   // Toggle the clock every half period
   always #1 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stall the result channel at random; change only on the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Compare one field and report a mismatch
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Match every result transfer against the oldest owed result
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual event %0d byte %0d",
                     $time, rsp_event_res, rsp_out_byte);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("event_res", int'(want.ev), int'(rsp_event_res));
            check_field("out_byte", int'(want.data), int'(rsp_out_byte));
            check_field("line_len", int'(want.len), int'(rsp_line_len));
            check_field("last", int'(want.last), int'(rsp_last));
         end
      end
   end

   // Advance the shadow editor by one accepted item and queue the results it owes
   task automatic edit_line(input logic typ, input logic [7:0] ch, input logic [6:0] idx,
                            input bit fixed, input line_result_type first);
      line_result_type owed [3];
      int           n    = 0;
      bit           quit = 0;
      if (typ == REQ_READ) begin
         owed[0] = '{EV_READ, (idx < line_count) ? line_mem[idx] : 8'h00, 7'd0, 1'b0};
         n = 1;
      end else begin
         if (line_ended) begin
            line_count = '0;
            plus_count = '0;
            esc_state  = ESC_NONE;
            line_ended = 1'b0;
         end
         // Three pluses in a row close the session before anything else
         if (ch == CH_PLUS) begin
            plus_count++;
            if (plus_count > 2) begin
               plus_count = '0;
               line_ended = 1'b1;
               owed[0] = '{EV_EXIT, 8'h00, 7'd0, 1'b0};
               n = 1;
               quit = 1;
            end
         end else begin
            plus_count = '0;
         end
         if (!quit) begin
            if (ch == CH_LF || ch == CH_CR) begin
               esc_state  = ESC_NONE;
               line_ended = 1'b1;
               owed[0] = '{EV_ECHO, CH_CR, 7'd0, 1'b0};
               owed[1] = '{EV_ECHO, CH_LF, 7'd0, 1'b0};
               owed[2] = '{EV_DONE, 8'h00, 7'd0, 1'b0};
               n = 3;
            end else if (ch == abort_code) begin
               esc_state  = ESC_NONE;
               line_count = '0;
               owed[0] = '{EV_ECHO, CH_CR, 7'd0, 1'b0};
               owed[1] = '{EV_ECHO, CH_LF, 7'd0, 1'b0};
               owed[2] = '{EV_PROMPT, 8'h00, 7'd0, 1'b0};
               n = 3;
            end else if (ch == erase_code) begin
               esc_state = ESC_NONE;
               if (line_count > 0) begin
                  line_count--;
                  owed[0] = '{EV_ECHO, CH_BS, 7'd0, 1'b0};
                  owed[1] = '{EV_ECHO, CH_SPACE, 7'd0, 1'b0};
                  owed[2] = '{EV_ECHO, CH_BS, 7'd0, 1'b0};
                  n = 3;
               end
            end else if (ch == CH_ESC) begin
               esc_state = ESC_OPEN;
            end else if (esc_state == ESC_OPEN && ch == intro_code) begin
               esc_state = ESC_INTRO;
            end else if (esc_state == ESC_INTRO) begin
               esc_state = ESC_NONE;
            end else begin
               // Ordinary byte: always echoed, stored only while there is room
               esc_state = ESC_NONE;
               owed[0] = '{EV_ECHO, ch, 7'd0, 1'b0};
               n = 1;
               if (line_count < LINE_CAP) begin
                  line_mem[line_count] = ch;
                  line_count++;
               end
            end
         end
      end
      if (fixed && n > 0) begin
         owed[0].ev   = first.ev;
         owed[0].data = first.data;
      end
      for (int k = 0; k < n; k++) begin
         owed[k].len  = (fixed && k == 0) ? first.len : line_count;
         owed[k].last = (k == n - 1);
         due_results.push_back(owed[k]);
      end
   endtask

   // Present one item from a falling edge, hold it until the transfer, return on a falling edge
   task automatic push_item(input logic typ, input logic [7:0] ch, input logic [6:0] idx,
                            input bit fixed = 0, input logic [2:0] ev = EV_ECHO,
                            input logic [7:0] data = 8'h00, input logic [6:0] len = 7'd0);
      bit done = 0;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= typ;
      req_rx_byte    <= ch;
      req_read_index <= idx;
      while (!done) begin
         @(posedge clock);
         done = !req_stall;
      end
      edit_line(typ, ch, idx, fixed, '{ev, data, len, 1'b0});
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every owed result has come and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Write all three registers back to back; psel stays high between writes
   task automatic configure(input logic [7:0] vals [3]);
      logic [1:0] which;
      for (int k = 0; k < 3; k++) begin
         which = k[1:0];
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {which, 2'b00};
         pwdata  <= {24'd0, vals[k]};
         @(negedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         case (which)
            CSR_ABORT:     abort_code = vals[k];
            CSR_BACKSPACE: erase_code = vals[k];
            CSR_INTRO:     intro_code = vals[k];
            default: ;
         endcase
         @(negedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Draw any byte
   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // Draw any line index
   function automatic logic [6:0] any_index();
      return 7'($urandom_range(0, 127));
   endfunction

   // Draw a byte that none of the current control codes claims
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = any_byte();
      while (b == CH_LF || b == CH_CR || b == CH_ESC || b == CH_PLUS ||
             b == abort_code || b == erase_code || b == intro_code)
         b = any_byte();
      return b;
   endfunction

   // Pick a read index: mostly inside the current line, sometimes anywhere
   function automatic logic [6:0] read_spot();
      if (line_count != 0 && $urandom_range(0, 1))
         return 7'($urandom_range(0, line_count - 1));
      return any_index();
   endfunction

   // Random byte or read with control codes weighted up
   task automatic noise_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) push_item(REQ_READ, any_byte(), any_index());
      else if (pick < 60) push_item(REQ_BYTE, any_byte(), any_index());
      else begin
         case ($urandom_range(0, 6))
            0: push_item(REQ_BYTE, CH_LF, any_index());
            1: push_item(REQ_BYTE, CH_CR, any_index());
            2: push_item(REQ_BYTE, abort_code, any_index());
            3: push_item(REQ_BYTE, erase_code, any_index());
            4: push_item(REQ_BYTE, CH_ESC, any_index());
            5: push_item(REQ_BYTE, intro_code, any_index());
            default: push_item(REQ_BYTE, CH_PLUS, any_index());
         endcase
      end
   endtask

   // Mostly whole lines with edits, escapes and reads; the rest noise.
   // A long line first runs the store past its capacity.
   task automatic run_batch(input int target, input bit long_first);
      int  stop_at;
      int  len;
      int  pick;
      bit  long_line;
      stop_at   = items_sent + target;
      long_line = long_first;
      while (items_sent < stop_at) begin
         if (long_line || $urandom_range(0, 99) < 70) begin
            len = long_line ? $urandom_range(140, 145) : $urandom_range(0, 12);
            for (int k = 0; k < len; k++) begin
               pick = long_line ? ((k % 20 == 19) ? 90 : 0) : $urandom_range(0, 99);
               if (pick < 62) push_item(REQ_BYTE, plain_byte(), any_index());
               else if (pick < 72) push_item(REQ_BYTE, erase_code, any_index());
               else if (pick < 80) begin
                  push_item(REQ_BYTE, CH_ESC, any_index());
                  push_item(REQ_BYTE, intro_code, any_index());
                  push_item(REQ_BYTE, any_byte(), any_index());
               end else if (pick < 84) begin
                  push_item(REQ_BYTE, CH_ESC, any_index());
                  push_item(REQ_BYTE, plain_byte(), any_index());
               end else if (pick < 95) push_item(REQ_READ, any_byte(), read_spot());
               else push_item(REQ_BYTE, CH_PLUS, any_index());
            end
            case ($urandom_range(0, 4))
               0: push_item(REQ_BYTE, CH_CR, any_index());
               1: push_item(REQ_BYTE, CH_LF, any_index());
               2: push_item(REQ_BYTE, abort_code, any_index());
               3: repeat (3) push_item(REQ_BYTE, CH_PLUS, any_index());
               default: ;
            endcase
            long_line = 0;
         end else begin
            noise_item();
         end
         if ($urandom_range(0, 59) == 0) drain();
      end
   endtask

   initial begin
      logic [7:0] regs [3];
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_BYTE;
      req_rx_byte    = 8'h00;
      req_read_index = 7'd0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;

      // Hold reset, then drop it on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table under the reset register values
      foreach (drill[r])
         push_item(drill[r].typ, drill[r].ch, drill[r].idx, drill[r].fixed,
                   drill[r].ev, drill[r].data, drill[r].len);

      // Random batches: idle profile moves every two batches, registers every batch
      for (int b = 0; b < 6; b++) begin
         drain();
         case (b / 2)
            0: begin send_gap_pct = 12; recv_stall_pct = 52; end
            1: begin send_gap_pct = 52; recv_stall_pct = 12; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
         endcase
         if (b < 5) regs = batch_regs[b];
         else foreach (regs[k]) regs[k] = any_byte();
         configure(regs);
         run_batch(BATCH_ITEMS, b == 1 || b == 4);
      end

      // Let every owed result come in, then settle
      drain();
      if (mismatches == 0 && due_results.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tle_pkg.sv
rtl/tle_ram.sv
rtl/terminal_line_editor.sv
test/testbench.sv
